// ===== design/nrdiv_pkg.sv =====
`default_nettype none

package nrdiv_pkg;

    localparam int FIELD_W = 16;

    typedef enum logic {
        STATUS_OK       = 1'b0,
        STATUS_DIV_ZERO = 1'b1
    } t_status;

    typedef struct packed {
        t_status              status;
        logic [FIELD_W-1:0]   remainder;
        logic [FIELD_W-1:0]   quotient;
    } t_result;

endpackage

`default_nettype wire

// ===== design/nrdiv_cell.sv =====
`default_nettype none

module nrdiv_cell #(
    parameter int WIDTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [WIDTH:0]     i_part,
    input  wire logic [WIDTH-1:0]   i_dq,
    input  wire logic [WIDTH-1:0]   i_dvs,
    input  wire logic               i_zero,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output logic [WIDTH:0]          o_part,
    output logic [WIDTH-1:0]        o_dq,
    output logic [WIDTH-1:0]        o_dvs,
    output logic                    o_zero
);

    logic                   r_valid;
    logic [WIDTH:0]         r_part;
    logic [WIDTH-1:0]       r_dq;
    logic [WIDTH-1:0]       r_dvs;
    logic                   r_zero;

    logic signed [WIDTH+1:0] w_shift;
    logic signed [WIDTH+1:0] w_m;
    logic signed [WIDTH+1:0] w_sum;
    logic [WIDTH:0]          n_part;
    logic [WIDTH-1:0]        n_dq;

    // The partial remainder is shifted left, taking in the next dividend bit, and the
    // divisor is added when it was negative and subtracted otherwise.
    always_comb begin
        w_shift = $signed({i_part, i_dq[WIDTH-1]});
        w_m     = $signed({2'b00, i_dvs});
        if (i_part[WIDTH]) begin
            w_sum = w_shift + w_m;
        end else begin
            w_sum = w_shift - w_m;
        end
        n_part = w_sum[WIDTH:0];
        n_dq   = {i_dq[WIDTH-2:0], ~w_sum[WIDTH+1]};
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_part <= n_part;
            r_dq   <= n_dq;
            r_dvs  <= i_dvs;
            r_zero <= i_zero;
        end
    end

    assign o_valid = r_valid;
    assign o_part  = r_part;
    assign o_dq    = r_dq;
    assign o_dvs   = r_dvs;
    assign o_zero  = r_zero;

endmodule

`default_nettype wire

// ===== design/nrdiv_fix.sv =====
`default_nettype none

module nrdiv_fix #(
    parameter int WIDTH = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_ready,
    input  wire logic [WIDTH:0]     i_part,
    input  wire logic [WIDTH-1:0]   i_quo,
    input  wire logic [WIDTH-1:0]   i_dvs,
    input  wire logic               i_zero,
    output logic                    o_valid,
    input  wire logic               i_ready,
    output nrdiv_pkg::t_result      o_result
);

    logic                   r_valid;
    nrdiv_pkg::t_result     r_result;
    nrdiv_pkg::t_result     n_result;
    logic [WIDTH:0]         w_rem;

    // A negative final remainder has the divisor added back once.
    always_comb begin
        if (i_part[WIDTH]) begin
            w_rem = i_part + {1'b0, i_dvs};
        end else begin
            w_rem = i_part;
        end
        if (i_zero) begin
            n_result.quotient  = '0;
            n_result.remainder = '0;
            n_result.status    = nrdiv_pkg::STATUS_DIV_ZERO;
        end else begin
            n_result.quotient  = nrdiv_pkg::FIELD_W'(i_quo);
            n_result.remainder = nrdiv_pkg::FIELD_W'(w_rem[WIDTH-1:0]);
            n_result.status    = nrdiv_pkg::STATUS_OK;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_result <= n_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== design/unsigned_nonrestoring_divider.sv =====
// Each item is registered in every divider cell and then in the correction stage.
// Throughput: one item per cycle unless i_m_tready holds back the output, set by one divider
// cell per quotient bit and one correction stage, each with its own register and handshake.
// Empty stages close up under back-pressure, so o_s_tready falls only when every stage is full.
// Reset (i_rst_n low, synchronous) clears all valid flags; data registers are not reset.
`default_nettype none

module unsigned_nonrestoring_divider #(
    parameter int WIDTH = 16
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_s_tvalid,
    output logic            o_s_tready,
    input  wire logic [31:0] i_s_tdata,   // dividend [15:0], divisor [31:16]
    output logic            o_m_tvalid,
    input  wire logic       i_m_tready,
    output logic [31:0]     o_m_tdata,    // quotient [15:0], remainder [31:16]
    output logic [0:0]      o_m_tuser     // status [0]
);

    localparam int STAGES = WIDTH + 1;
    localparam int CNT_W  = $clog2(STAGES + 1);

    logic [WIDTH:0]     w_part  [0:WIDTH];
    logic [WIDTH-1:0]   w_dq    [0:WIDTH];
    logic [WIDTH-1:0]   w_dvs   [0:WIDTH];
    logic               w_zero  [0:WIDTH];
    logic               w_valid [0:WIDTH];
    logic               w_ready [0:WIDTH];

    logic [WIDTH-1:0]   w_dvd_in;
    logic [WIDTH-1:0]   w_dvs_in;
    nrdiv_pkg::t_result w_result;

    assign w_dvd_in = WIDTH'(i_s_tdata[15:0]);
    assign w_dvs_in = WIDTH'(i_s_tdata[31:16]);

    assign w_part[0]  = '0;
    assign w_dq[0]    = w_dvd_in;
    assign w_dvs[0]   = w_dvs_in;
    assign w_zero[0]  = (w_dvs_in == '0);
    assign w_valid[0] = i_s_tvalid;
    assign o_s_tready = w_ready[0];

    for (genvar g = 0; g < WIDTH; g++) begin : g_cell
        nrdiv_cell #(
            .WIDTH (WIDTH)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[g]),
            .o_ready (w_ready[g]),
            .i_part  (w_part[g]),
            .i_dq    (w_dq[g]),
            .i_dvs   (w_dvs[g]),
            .i_zero  (w_zero[g]),
            .o_valid (w_valid[g+1]),
            .i_ready (w_ready[g+1]),
            .o_part  (w_part[g+1]),
            .o_dq    (w_dq[g+1]),
            .o_dvs   (w_dvs[g+1]),
            .o_zero  (w_zero[g+1])
        );
    end

    nrdiv_fix #(
        .WIDTH (WIDTH)
    ) u_fix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (w_valid[WIDTH]),
        .o_ready  (w_ready[WIDTH]),
        .i_part   (w_part[WIDTH]),
        .i_quo    (w_dq[WIDTH]),
        .i_dvs    (w_dvs[WIDTH]),
        .i_zero   (w_zero[WIDTH]),
        .o_valid  (o_m_tvalid),
        .i_ready  (i_m_tready),
        .o_result (w_result)
    );

    assign o_m_tdata = {w_result.remainder, w_result.quotient};
    assign o_m_tuser = w_result.status;

    // Items in flight, kept for the checks below.
    logic [CNT_W-1:0] r_inflight;
    logic [CNT_W-1:0] n_inflight;

    always_comb begin
        n_inflight = r_inflight;
        if ((i_s_tvalid && o_s_tready) && !(o_m_tvalid && i_m_tready)) begin
            n_inflight = r_inflight + CNT_W'(1);
        end else if (!(i_s_tvalid && o_s_tready) && (o_m_tvalid && i_m_tready)) begin
            n_inflight = r_inflight - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inflight <= '0;
        end else begin
            r_inflight <= n_inflight;
        end
    end

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_tvalid && o_m_tuser[0] == nrdiv_pkg::STATUS_DIV_ZERO) |-> (o_m_tdata == '0))
        else $error("division by zero result carries non-zero data");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_tready |-> (o_m_tvalid && !i_m_tready))
        else $error("input stalled without output back-pressure");

    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid straight after reset");

    a_inflight_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inflight <= CNT_W'(STAGES))
        else $error("more items in flight than pipeline stages");

    a_valid_has_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (r_inflight != '0))
        else $error("result shown with no item in flight");

endmodule

`default_nettype wire
